>>> rtl/bitmanip_alu_rv64_core_macros.svh
// Assertion helpers shared by the RTL that checks itself.
`ifndef BITMANIP_ALU_RV64_CORE_MACROS_SVH
`define BITMANIP_ALU_RV64_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BMA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/bma_pkg.sv
package bma_pkg;

   localparam int XLEN   = 64;
   localparam int WORD_W = 32;
   localparam int CMD_W  = 5;
   localparam int CNT_W  = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD_UW    = 5'd0,
      CMD_SH1ADD    = 5'd1,
      CMD_SH2ADD    = 5'd2,
      CMD_SH3ADD    = 5'd3,
      CMD_SH1ADD_UW = 5'd4,
      CMD_SH2ADD_UW = 5'd5,
      CMD_SH3ADD_UW = 5'd6,
      CMD_SLLI_UW   = 5'd7,
      CMD_ANDN      = 5'd8,
      CMD_ORN       = 5'd9,
      CMD_XNOR      = 5'd10,
      CMD_CLZ       = 5'd11,
      CMD_CLZW      = 5'd12,
      CMD_CTZ       = 5'd13,
      CMD_CTZW      = 5'd14,
      CMD_CPOP      = 5'd15,
      CMD_CPOPW     = 5'd16,
      CMD_MIN       = 5'd17,
      CMD_MINU      = 5'd18,
      CMD_MAX       = 5'd19,
      CMD_MAXU      = 5'd20,
      CMD_SEXT_B    = 5'd21,
      CMD_SEXT_H    = 5'd22,
      CMD_ZEXT_W    = 5'd23,
      CMD_ZEXT_H    = 5'd24,
      CMD_ROL       = 5'd25,
      CMD_ROLW      = 5'd26,
      CMD_ROR       = 5'd27,
      CMD_RORW      = 5'd28,
      CMD_ORC_B     = 5'd29,
      CMD_REV8      = 5'd30
   } cmd_type;

endpackage

>>> rtl/bitmanip_alu_rv64_core.sv
// Channel | Ports                                          | Moves
// req     | req_valid, req_ready, req_command, req_operand_a, req_operand_b | one op word in
// rsp     | rsp_valid, rsp_ready, rsp_result               | one result word out
//
// Two-stage pipeline: input register, single-pass ALU logic, result register.
// A word is accepted every cycle unless both stages are full; rsp shows the result register.
// The critical path is the 64-bit adder or count logic between the two registers.
// Synchronous active-high reset clears both stage valids; payload is not reset.
// A stalled rsp holds the result register; the input register keeps accepting
// until both stages are full.
`include "bitmanip_alu_rv64_core_macros.svh"

module bitmanip_alu_rv64_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bma_pkg::CMD_W-1:0]       req_command,
   input  logic [bma_pkg::XLEN-1:0]        req_operand_a,
   input  logic [bma_pkg::XLEN-1:0]        req_operand_b,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bma_pkg::XLEN-1:0]        rsp_result
);

   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   logic [bma_pkg::CMD_W-1:0]   s1_command_ff;
   logic [bma_pkg::CMD_W-1:0]   s1_command_in;
   logic [bma_pkg::XLEN-1:0]    s1_operand_a_ff;
   logic [bma_pkg::XLEN-1:0]    s1_operand_a_in;
   logic [bma_pkg::XLEN-1:0]    s1_operand_b_ff;
   logic [bma_pkg::XLEN-1:0]    s1_operand_b_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [bma_pkg::XLEN-1:0]    rsp_result_ff;
   logic [bma_pkg::XLEN-1:0]    rsp_result_in;
   logic [bma_pkg::XLEN-1:0]    alu_result;
   logic                        s1_advance;
   logic                        req_take;

   bma_alu u_alu (
      .command   (s1_command_ff),
      .operand_a (s1_operand_a_ff),
      .operand_b (s1_operand_b_ff),
      .result    (alu_result)
   );

   // advance stage 1 when the result register is empty or being drained
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;

   always_comb begin
      s1_valid_in     = req_take || (s1_valid_ff && !s1_advance);
      s1_command_in   = s1_command_ff;
      s1_operand_a_in = s1_operand_a_ff;
      s1_operand_b_in = s1_operand_b_ff;
      if (req_take) begin
         s1_command_in   = req_command;
         s1_operand_a_in = req_operand_a;
         s1_operand_b_in = req_operand_b;
      end
   end

   always_comb begin
      rsp_valid_in  = s1_advance || (rsp_valid_ff && !rsp_ready);
      rsp_result_in = s1_advance ? alu_result : rsp_result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_command_ff   <= s1_command_in;
      s1_operand_a_ff <= s1_operand_a_in;
      s1_operand_b_ff <= s1_operand_b_in;
      rsp_result_ff   <= rsp_result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   `BMA_ASSERT_NEXT(a_take_fills_s1, clock, reset, req_take, s1_valid_ff, "accepted word lost")
   `BMA_ASSERT_NEXT(a_advance_result, clock, reset, s1_advance, rsp_valid_ff && rsp_result_ff == $past(alu_result), "result register missed ALU output")
   `BMA_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_advance, s1_valid_ff && $stable(s1_operand_a_ff) && $stable(s1_command_ff), "stalled stage 1 changed")
   `BMA_ASSERT_SAME(a_ready_only_full, clock, reset, !req_ready, s1_valid_ff && rsp_valid_ff && !rsp_ready, "input blocked without full pipeline")

endmodule

>>> rtl/bma_alu.sv
module bma_alu (
   input  logic [bma_pkg::CMD_W-1:0] command,
   input  logic [bma_pkg::XLEN-1:0]  operand_a,
   input  logic [bma_pkg::XLEN-1:0]  operand_b,
   output logic [bma_pkg::XLEN-1:0]  result
);

   localparam int XL = bma_pkg::XLEN;
   localparam int WL = bma_pkg::WORD_W;
   localparam int CW = bma_pkg::CNT_W;

   // Leading zeros: per-byte priority encode, then pick the highest nonzero byte.
   function automatic logic [CW-1:0] lead_zeros64(input logic [XL-1:0] v);
      logic [3:0]    byte_lz [8];
      logic [7:0]    byte_nz;
      logic [CW-1:0] n;
      for (int b = 0; b < 8; b++) begin
         byte_lz[b] = 4'd8;
         for (int k = 0; k < 8; k++) begin
            if (v[8*b+k]) begin
               byte_lz[b] = 4'(7 - k);
            end
         end
         byte_nz[b] = |v[8*b +: 8];
      end
      n = CW'(XL);
      for (int b = 0; b < 8; b++) begin
         if (byte_nz[b]) begin
            n = {1'b0, 3'(7 - b), byte_lz[b][2:0]};
         end
      end
      return n;
   endfunction

   function automatic logic [CW-1:0] pop64(input logic [XL-1:0] v);
      logic [3:0]    byte_cnt [8];
      logic [CW-1:0] n;
      for (int b = 0; b < 8; b++) begin
         byte_cnt[b] = 4'd0;
         for (int k = 0; k < 8; k++) begin
            byte_cnt[b] = byte_cnt[b] + 4'(v[8*b+k]);
         end
      end
      n = '0;
      for (int b = 0; b < 8; b++) begin
         n = n + CW'(byte_cnt[b]);
      end
      return n;
   endfunction

   bma_pkg::cmd_type cmd;
   logic [XL-1:0]    a_uw;
   logic [XL-1:0]    a_rev;
   logic [XL-1:0]    a_low_rev;
   logic [WL-1:0]    a_word;
   logic [5:0]       sh6;
   logic [4:0]       sh5;
   logic [2*XL-1:0]  rol_wide;
   logic [2*XL-1:0]  ror_wide;
   logic [2*WL-1:0]  rolw_wide;
   logic [2*WL-1:0]  rorw_wide;
   logic [WL-1:0]    rolw_word;
   logic [WL-1:0]    rorw_word;
   logic [XL-1:0]    orc_bytes;
   logic [XL-1:0]    rev_bytes;
   logic             lt_signed;
   logic             lt_unsigned;

   assign cmd    = bma_pkg::cmd_type'(command);
   assign a_word = operand_a[WL-1:0];
   assign a_uw   = {{(XL-WL){1'b0}}, a_word};
   assign sh6    = operand_b[5:0];
   assign sh5    = operand_b[4:0];

   // Trailing zeros reuse the leading-zero encoder on the bit-reversed word.
   assign a_rev     = {<<{operand_a}};
   assign a_low_rev = {<<{{{(XL-WL){1'b1}}, a_word}}};

   // Rotates: shift a doubled copy and keep one half.
   assign rol_wide  = {operand_a, operand_a} << sh6;
   assign ror_wide  = {operand_a, operand_a} >> sh6;
   assign rolw_wide = {a_word, a_word} << sh5;
   assign rorw_wide = {a_word, a_word} >> sh5;
   assign rolw_word = rolw_wide[2*WL-1:WL];
   assign rorw_word = rorw_wide[WL-1:0];

   assign lt_signed   = $signed(operand_a) < $signed(operand_b);
   assign lt_unsigned = operand_a < operand_b;

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         orc_bytes[8*b +: 8] = {8{|operand_a[8*b +: 8]}};
         rev_bytes[8*b +: 8] = operand_a[8*(7-b) +: 8];
      end
   end

   always_comb begin
      case (cmd)
         bma_pkg::CMD_ADD_UW:    result = a_uw + operand_b;
         bma_pkg::CMD_SH1ADD:    result = (operand_a << 1) + operand_b;
         bma_pkg::CMD_SH2ADD:    result = (operand_a << 2) + operand_b;
         bma_pkg::CMD_SH3ADD:    result = (operand_a << 3) + operand_b;
         bma_pkg::CMD_SH1ADD_UW: result = (a_uw << 1) + operand_b;
         bma_pkg::CMD_SH2ADD_UW: result = (a_uw << 2) + operand_b;
         bma_pkg::CMD_SH3ADD_UW: result = (a_uw << 3) + operand_b;
         bma_pkg::CMD_SLLI_UW:   result = a_uw << sh6;
         bma_pkg::CMD_ANDN:      result = operand_a & ~operand_b;
         bma_pkg::CMD_ORN:       result = operand_a | ~operand_b;
         bma_pkg::CMD_XNOR:      result = operand_a ^ ~operand_b;
         bma_pkg::CMD_CLZ:       result = XL'(lead_zeros64(operand_a));
         // pad with ones so a zero word counts to 32
         bma_pkg::CMD_CLZW:      result = XL'(lead_zeros64({a_word, {(XL-WL){1'b1}}}));
         bma_pkg::CMD_CTZ:       result = XL'(lead_zeros64(a_rev));
         bma_pkg::CMD_CTZW:      result = XL'(lead_zeros64(a_low_rev));
         bma_pkg::CMD_CPOP:      result = XL'(pop64(operand_a));
         bma_pkg::CMD_CPOPW:     result = XL'(pop64(a_uw));
         bma_pkg::CMD_MIN:       result = lt_signed ? operand_a : operand_b;
         bma_pkg::CMD_MINU:      result = lt_unsigned ? operand_a : operand_b;
         bma_pkg::CMD_MAX:       result = lt_signed ? operand_b : operand_a;
         bma_pkg::CMD_MAXU:      result = lt_unsigned ? operand_b : operand_a;
         bma_pkg::CMD_SEXT_B:    result = {{(XL-8){operand_a[7]}}, operand_a[7:0]};
         bma_pkg::CMD_SEXT_H:    result = {{(XL-16){operand_a[15]}}, operand_a[15:0]};
         bma_pkg::CMD_ZEXT_W:    result = a_uw;
         bma_pkg::CMD_ZEXT_H:    result = {{(XL-16){1'b0}}, operand_a[15:0]};
         bma_pkg::CMD_ROL:       result = rol_wide[2*XL-1:XL];
         bma_pkg::CMD_ROLW:      result = {{(XL-WL){rolw_word[WL-1]}}, rolw_word};
         bma_pkg::CMD_ROR:       result = ror_wide[XL-1:0];
         bma_pkg::CMD_RORW:      result = {{(XL-WL){rorw_word[WL-1]}}, rorw_word};
         bma_pkg::CMD_ORC_B:     result = orc_bytes;
         bma_pkg::CMD_REV8:      result = rev_bytes;
         default:                result = '0;
      endcase
   end

endmodule

>>> verif/bitmanip_alu_rv64_core_test.sv
`timescale 1ns / 100ps

module bitmanip_alu_rv64_core_test;

   localparam int CW = bma_pkg::CMD_W;
   localparam int XW = bma_pkg::XLEN;
   localparam int WW = bma_pkg::WORD_W;
   localparam logic [CW-1:0] CMD_UNDEFINED = 5'd31;
   localparam int RANDOM_WORDS = 1950;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_EVERY = 500;

   typedef struct {
      logic [CW-1:0] command;
      logic [XW-1:0] operand_a;
      logic [XW-1:0] operand_b;
      bit            drain_first;
   } alu_word_type;

   typedef struct {
      alu_word_type  word;
      logic [XW-1:0] result;
   } alu_expect_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CW-1:0]       req_command = '0;
   logic [XW-1:0]       req_operand_a = '0;
   logic [XW-1:0]       req_operand_b = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [XW-1:0]       rsp_result;

   alu_word_type   pending_words[$];
   alu_expect_type expected_results[$];
   alu_word_type   held_word;
   bit          req_fired = 1'b0;
   int          req_gap = 0;
   int          rsp_stall = 0;
   int          quiet_cycles = 0;
   int          cycle_count = 0;
   int          words_accepted = 0;
   int          results_checked = 0;
   int          error_count = 0;
   logic [31:0] command_hits = '0;

   bitmanip_alu_rv64_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_result    (rsp_result)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [XW-1:0] alu_result(logic [CW-1:0] command,
                                                logic [XW-1:0] a, logic [XW-1:0] b);
      logic [XW-1:0]   r;
      logic [WW-1:0]   w;
      logic [WW-1:0]   rw;
      logic [2*XW-1:0] dbl;
      logic [XW-1:0]   dblw;
      r = '0;
      w = a[WW-1:0];
      case (command)
         bma_pkg::CMD_ADD_UW:    r = {32'b0, w} + b;
         bma_pkg::CMD_SH1ADD:    r = (a << 1) + b;
         bma_pkg::CMD_SH2ADD:    r = (a << 2) + b;
         bma_pkg::CMD_SH3ADD:    r = (a << 3) + b;
         bma_pkg::CMD_SH1ADD_UW: r = ({32'b0, w} << 1) + b;
         bma_pkg::CMD_SH2ADD_UW: r = ({32'b0, w} << 2) + b;
         bma_pkg::CMD_SH3ADD_UW: r = ({32'b0, w} << 3) + b;
         bma_pkg::CMD_SLLI_UW:   r = {32'b0, w} << b[5:0];
         bma_pkg::CMD_ANDN:      r = a & ~b;
         bma_pkg::CMD_ORN:       r = a | ~b;
         bma_pkg::CMD_XNOR:      r = a ^ ~b;
         bma_pkg::CMD_CLZ: begin
            r = 64'd64;
            for (int i = 0; i < XW; i++) if (a[i]) r = 64'(XW - 1 - i);
         end
         bma_pkg::CMD_CLZW: begin
            r = 64'd32;
            for (int i = 0; i < WW; i++) if (w[i]) r = 64'(WW - 1 - i);
         end
         bma_pkg::CMD_CTZ: begin
            r = 64'd64;
            for (int i = XW - 1; i >= 0; i--) if (a[i]) r = 64'(i);
         end
         bma_pkg::CMD_CTZW: begin
            r = 64'd32;
            for (int i = WW - 1; i >= 0; i--) if (w[i]) r = 64'(i);
         end
         bma_pkg::CMD_CPOP: begin
            for (int i = 0; i < XW; i++) r = r + 64'(a[i]);
         end
         bma_pkg::CMD_CPOPW: begin
            for (int i = 0; i < WW; i++) r = r + 64'(w[i]);
         end
         bma_pkg::CMD_MIN:    r = ($signed(a) < $signed(b)) ? a : b;
         bma_pkg::CMD_MINU:   r = (a < b) ? a : b;
         bma_pkg::CMD_MAX:    r = ($signed(a) < $signed(b)) ? b : a;
         bma_pkg::CMD_MAXU:   r = (a < b) ? b : a;
         bma_pkg::CMD_SEXT_B: r = {{56{a[7]}}, a[7:0]};
         bma_pkg::CMD_SEXT_H: r = {{48{a[15]}}, a[15:0]};
         bma_pkg::CMD_ZEXT_W: r = {32'b0, w};
         bma_pkg::CMD_ZEXT_H: r = {48'b0, a[15:0]};
         bma_pkg::CMD_ROL: begin
            dbl = {a, a} << b[5:0];
            r = dbl[2*XW-1:XW];
         end
         bma_pkg::CMD_ROLW: begin
            dblw = {w, w} << b[4:0];
            rw = dblw[XW-1:WW];
            r = {{32{rw[31]}}, rw};
         end
         bma_pkg::CMD_ROR: begin
            dbl = {a, a} >> b[5:0];
            r = dbl[XW-1:0];
         end
         bma_pkg::CMD_RORW: begin
            dblw = {w, w} >> b[4:0];
            rw = dblw[WW-1:0];
            r = {{32{rw[31]}}, rw};
         end
         bma_pkg::CMD_ORC_B: begin
            for (int i = 0; i < 8; i++) r[8*i +: 8] = {8{|a[8*i +: 8]}};
         end
         bma_pkg::CMD_REV8: begin
            for (int i = 0; i < 8; i++) r[8*(7-i) +: 8] = a[8*i +: 8];
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   // Biased toward zeros, all ones, lone bits and sparse bytes so the counts,
   // orc.b and the shifts see their edges often.
   function automatic logic [XW-1:0] random_operand();
      logic [XW-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = '1;
         2: v = 64'd1 << $urandom_range(0, 63);
         3: v[31:0] = '0;
         4: begin
            for (int i = 0; i < 8; i++) if ($urandom_range(0, 1)) v[8*i +: 8] = '0;
         end
         5: v = v >> $urandom_range(1, 63);
         6: v = v << $urandom_range(1, 63);
         default: ;
      endcase
      return v;
   endfunction

   // Mostly short gaps, a few long ones, none during a quiet stretch.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_cycles > 0 || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Request driver: hold the word until taken, then idle or advance.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_command <= '0;
         req_operand_a <= '0;
         req_operand_b <= '0;
      end else if (req_valid && !req_fired) begin
         req_valid <= 1'b1;
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap--;
      end else if (pending_words.size() != 0 &&
                   !(pending_words[0].drain_first && expected_results.size() != 0)) begin
         held_word = pending_words.pop_front();
         req_valid <= 1'b1;
         req_command <= held_word.command;
         req_operand_a <= held_word.operand_a;
         req_operand_b <= held_word.operand_b;
         req_gap = pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall = pick_gap();
      end
   end

   // Monitor: retire the oldest expectation first, then record the new word.
   always @(posedge clock) begin
      alu_expect_type got;
      alu_expect_type fresh;
      cycle_count++;
      if (quiet_cycles > 0) quiet_cycles--;
      else if ($urandom_range(0, 299) == 0) quiet_cycles = $urandom_range(50, 150);
      if (reset) begin
         req_fired = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result: unexpected word %h with nothing outstanding", rsp_result);
               error_count++;
            end else begin
               got = expected_results.pop_front();
               if (rsp_result !== got.result) begin
                  $error("result: expected %h, actual %h (command %0d, a %h, b %h)",
                         got.result, rsp_result, got.word.command, got.word.operand_a,
                         got.word.operand_b);
                  error_count++;
               end
               results_checked++;
            end
         end
         req_fired = req_valid && req_ready;
         if (req_fired) begin
            fresh.word.command = req_command;
            fresh.word.operand_a = req_operand_a;
            fresh.word.operand_b = req_operand_b;
            fresh.word.drain_first = 1'b0;
            fresh.result = alu_result(req_command, req_operand_a, req_operand_b);
            expected_results.push_back(fresh);
            command_hits[req_command] = 1'b1;
            words_accepted++;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("bitmanip_alu_rv64_core_test: errors");
      $finish;
   end

   initial begin
      alu_word_type word;
      int total_words;
      int codes_seen;
      // One directed word per command code, operands picked at the edges.
      for (int c = 0; c < 32; c++) begin
         word.command = CW'(c);
         word.drain_first = 1'b0;
         word.operand_a = 64'hFFFF_FFFF_FFFF_FFFF;
         word.operand_b = 64'hFFFF_FFFF_FFFF_FFFF;
         case (word.command)
            bma_pkg::CMD_SH1ADD, bma_pkg::CMD_SH2ADD, bma_pkg::CMD_SH3ADD:
               word.operand_a = 64'h8000_0000_0000_0001;
            bma_pkg::CMD_SLLI_UW: word.operand_b = 64'h0000_0000_0000_007F;
            bma_pkg::CMD_ANDN, bma_pkg::CMD_ORN, bma_pkg::CMD_XNOR:
               word.operand_b = 64'h0F0F_F0F0_00FF_FF00;
            bma_pkg::CMD_CLZ, bma_pkg::CMD_CTZ: word.operand_a = '0;
            bma_pkg::CMD_CLZW, bma_pkg::CMD_CTZW: word.operand_a = 64'hFFFF_FFFF_0000_0000;
            bma_pkg::CMD_CPOPW: word.operand_a = 64'h0000_0000_FFFF_FFFF;
            bma_pkg::CMD_MIN, bma_pkg::CMD_MINU, bma_pkg::CMD_MAX, bma_pkg::CMD_MAXU: begin
               word.operand_a = 64'h8000_0000_0000_0000;
               word.operand_b = 64'h7FFF_FFFF_FFFF_FFFF;
            end
            bma_pkg::CMD_SEXT_B: word.operand_a = 64'h0000_0000_0000_0080;
            bma_pkg::CMD_SEXT_H: word.operand_a = 64'h0000_0000_0000_8000;
            bma_pkg::CMD_ROL: begin
               word.operand_a = 64'h8000_0000_0000_0001;
               word.operand_b = 64'hFFFF_FFFF_FFFF_FFC1;
            end
            bma_pkg::CMD_ROLW: begin
               word.operand_a = 64'h1234_5678_4000_0001;
               word.operand_b = 64'h0000_0000_0000_0020;
            end
            bma_pkg::CMD_ROR: begin
               word.operand_a = 64'h0123_4567_89AB_CDEF;
               word.operand_b = '0;
            end
            bma_pkg::CMD_RORW: begin
               word.operand_a = 64'h0000_0000_0000_0001;
               word.operand_b = 64'h0000_0000_0000_003F;
            end
            bma_pkg::CMD_ORC_B: word.operand_a = 64'h0100_0000_8000_0200;
            bma_pkg::CMD_REV8: word.operand_a = 64'h0123_4567_89AB_CDEF;
            CMD_UNDEFINED: word.operand_a = 64'h0123_4567_89AB_CDEF;
            default: ;
         endcase
         pending_words.push_back(word);
      end
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         word.command = CW'($urandom_range(0, 31));
         word.operand_a = random_operand();
         word.operand_b = ($urandom_range(0, 9) == 0) ? word.operand_a : random_operand();
         // Let the pipe run dry now and then before the next word.
         word.drain_first = (n % DRAIN_EVERY == 0);
         pending_words.push_back(word);
      end
      total_words = pending_words.size();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (words_accepted < total_words) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      codes_seen = 0;
      for (int c = 0; c < 32; c++) codes_seen += int'(command_hits[c]);
      $display("%0d words checked over %0d of 32 command codes,", results_checked, codes_seen);
      $display("with random gaps on the request side and stalls on the result side.");
      if (error_count == 0) $display("bitmanip_alu_rv64_core_test: clean");
      else $display("bitmanip_alu_rv64_core_test: errors");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/bma_pkg.sv
rtl/bma_alu.sv
rtl/bitmanip_alu_rv64_core.sv
verif/bitmanip_alu_rv64_core_test.sv
